@@ rtl/bdlp_pkg.sv @@
// Package for the button debouncer with long-press detection.
// Holds the sizes, the configuration register codes, the reset values and the shared types.
// It depends on nothing else.
package bdlp_pkg;

  localparam int unsigned NumButtons = 5;
  localparam int unsigned PinW       = 5;
  localparam int unsigned DebW       = 8;
  localparam int unsigned HoldW      = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [DebW-1:0]  DebounceCountRst  = DebW'(10);
  localparam logic [HoldW-1:0] LongPressTicksRst = HoldW'(100);
  localparam logic             LongPressEnRst    = 1'b1;
  localparam logic             ScanEnRst         = 1'b0;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDebounceCount  = 2'd0,
    CfgLongPressTicks = 2'd1,
    CfgLongPressEn    = 2'd2,
    CfgScanEn         = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DebW-1:0]  debounce_count;
    logic [HoldW-1:0] long_press_ticks;
    logic             long_press_enable;
    logic             scan_enable;
  } cfg_t;

  typedef struct packed {
    logic press;
    logic rel;
    logic long_press;
  } lane_evt_t;

  typedef struct packed {
    logic [PinW-1:0] press_events;
    logic [PinW-1:0] release_events;
    logic [PinW-1:0] long_press_events;
  } result_t;

endpackage

@@ rtl/bdlp_if.sv @@
// Channel interfaces of the button debouncer: tick input, event output and register writes.
// Each carries valid, ready and its payload, with a source and a sink modport.
// They depend on bdlp_pkg.
interface bdlp_in_if import bdlp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PinW-1:0] pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink (input valid, input pin_levels, output ready);
endinterface

interface bdlp_out_if import bdlp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PinW-1:0] press_events;
  logic [PinW-1:0] release_events;
  logic [PinW-1:0] long_press_events;

  modport source (output valid, output press_events, output release_events,
                  output long_press_events, input ready);
  modport sink (input valid, input press_events, input release_events,
                input long_press_events, output ready);
endinterface

interface bdlp_cfg_if import bdlp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  reg_index;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

@@ rtl/bdlp_lane.sv @@
// One button lane: debounce counter, debounced level, hold counter and long-press flag.
// The state advances once for every processed tick; events are valid in that cycle.
// It depends on bdlp_pkg.
module bdlp_lane import bdlp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  cfg_t      cfg_i,
  input  logic      level_i,
  output lane_evt_t evt_o
);

  logic             stable_q, stable_d;
  logic [DebW-1:0]  mismatch_q, mismatch_d;
  logic [HoldW-1:0] hold_q, hold_d;
  logic             fired_q, fired_d;
  lane_evt_t        evt;

  always_comb begin
    logic [DebW-1:0]  mismatch_inc;
    logic [HoldW-1:0] hold_inc;
    stable_d     = stable_q;
    mismatch_d   = mismatch_q;
    hold_d       = hold_q;
    fired_d      = fired_q;
    evt          = '0;
    mismatch_inc = (mismatch_q == '1) ? mismatch_q : mismatch_q + DebW'(1);
    if (level_i != stable_q) begin
      if (mismatch_inc >= cfg_i.debounce_count) begin
        stable_d   = level_i;
        mismatch_d = '0;
        if (!level_i) begin
          evt.press = 1'b1;
        end else begin
          evt.rel = 1'b1;
          fired_d = 1'b0;
          hold_d  = '0;
        end
      end else begin
        mismatch_d = mismatch_inc;
      end
    end else begin
      mismatch_d = '0;
    end
    hold_inc = (hold_d == '1) ? hold_d : hold_d + HoldW'(1);
    if (cfg_i.long_press_enable && !fired_d && !stable_d) begin
      if (hold_inc >= cfg_i.long_press_ticks) begin
        hold_d         = '0;
        fired_d        = 1'b1;
        evt.long_press = 1'b1;
      end else begin
        hold_d = hold_inc;
      end
    end
  end

  assign evt_o = step_i ? evt : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q   <= 1'b1;
      mismatch_q <= '0;
      hold_q     <= '0;
      fired_q    <= 1'b0;
    end else if (step_i) begin
      stable_q   <= stable_d;
      mismatch_q <= mismatch_d;
      hold_q     <= hold_d;
      fired_q    <= fired_d;
    end
  end

endmodule

@@ rtl/button_debounce_long_press_core.sv @@
// Top level of the button debouncer with long-press detection.
// It depends on bdlp_pkg, the channel interfaces in bdlp_if and bdlp_lane.
//
// Each tick transfer carries the raw levels of all buttons (0 is active) and gives exactly one
// result transfer with press, release and long-press bits. A tick passes an input register and
// then the result register before its result is offered. A new tick is taken in every cycle
// while the result is not stalled, and while a result waits the input register can still take
// one more tick. Every button lane updates in the same cycle. While scanning is disabled the state
// is left alone and each tick returns an all-zero result. Registers must be written only while no
// tick is in flight; the block itself does not enforce this.
module button_debounce_long_press_core import bdlp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bdlp_in_if.sink    tick_i,
  bdlp_out_if.source result_o,
  bdlp_cfg_if.sink   cfg_i
);

  cfg_t                  cfg_q;
  logic                  in_valid_q;
  logic [PinW-1:0]       pin_q;
  logic                  out_valid_q;
  result_t               res_q, res_d;
  logic                  out_free;
  logic                  advance;
  logic                  step;
  logic [NumButtons-1:0] press_v, rel_v, long_v;

  assign out_free     = !out_valid_q || result_o.ready;
  assign advance      = in_valid_q && out_free;
  assign step         = advance && cfg_q.scan_enable;
  assign tick_i.ready = !in_valid_q || out_free;
  assign cfg_i.ready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_count    <= DebounceCountRst;
      cfg_q.long_press_ticks  <= LongPressTicksRst;
      cfg_q.long_press_enable <= LongPressEnRst;
      cfg_q.scan_enable       <= ScanEnRst;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.reg_index))
        CfgDebounceCount:  cfg_q.debounce_count    <= cfg_i.wdata[DebW-1:0];
        CfgLongPressTicks: cfg_q.long_press_ticks  <= cfg_i.wdata[HoldW-1:0];
        CfgLongPressEn:    cfg_q.long_press_enable <= cfg_i.wdata[0];
        CfgScanEn:         cfg_q.scan_enable       <= cfg_i.wdata[0];
        default: begin
        end
      endcase
    end
  end

  for (genvar b = 0; b < NumButtons; b++) begin : g_lane
    logic      level;
    lane_evt_t evt;

    if (b < PinW) begin : g_pin
      assign level = pin_q[b];
    end else begin : g_tied
      assign level = 1'b0;
    end

    bdlp_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (step),
      .cfg_i  (cfg_q),
      .level_i(level),
      .evt_o  (evt)
    );

    assign press_v[b] = evt.press;
    assign rel_v[b]   = evt.rel;
    assign long_v[b]  = evt.long_press;
  end

  for (genvar b = 0; b < PinW; b++) begin : g_res
    if (b < NumButtons) begin : g_used
      assign res_d.press_events[b]      = press_v[b];
      assign res_d.release_events[b]    = rel_v[b];
      assign res_d.long_press_events[b] = long_v[b];
    end else begin : g_unused
      assign res_d.press_events[b]      = 1'b0;
      assign res_d.release_events[b]    = 1'b0;
      assign res_d.long_press_events[b] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (tick_i.valid && tick_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i.valid && tick_i.ready) begin
      pin_q <= tick_i.pin_levels;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid             = out_valid_q;
  assign result_o.press_events      = res_q.press_events;
  assign result_o.release_events    = res_q.release_events;
  assign result_o.long_press_events = res_q.long_press_events;

endmodule

@@ rtl/bdlp_checker.sv @@
// Port-level checks for the button debouncer, attached to the top level by a bind.
// It watches the result channel only and depends on bdlp_pkg.
module bdlp_checker import bdlp_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid,
  input logic            out_ready,
  input logic [PinW-1:0] press_events,
  input logic [PinW-1:0] release_events,
  input logic [PinW-1:0] long_press_events
);

  a_no_press_and_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> ((press_events & release_events) == '0))
    else $error("press and release reported for the same button in one transfer");

  a_no_long_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> ((long_press_events & release_events) == '0))
    else $error("long press reported for a button that is being released");

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before its transfer");

  a_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(press_events) && $stable(release_events)
                                && $stable(long_press_events))
    else $error("stalled result changed");

endmodule

bind button_debounce_long_press_core bdlp_checker u_bdlp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid        (result_o.valid),
  .out_ready        (result_o.ready),
  .press_events     (result_o.press_events),
  .release_events   (result_o.release_events),
  .long_press_events(result_o.long_press_events)
);
